### src/ckab_pkg.sv
package ckab_pkg;

    // image geometry
    localparam int WIDTH        = 256;
    localparam int HEIGHT       = 256;
    localparam int FRAME_PIXELS = WIDTH * HEIGHT;

    // line window: two rows plus one pixel
    localparam int WIN_DEPTH = 2 * WIDTH + 1;
    localparam int WIN_AW    = $clog2(WIN_DEPTH);

    // widths
    localparam int PIX_W  = 24;
    localparam int OUT_W  = 32;
    localparam int X_W    = $clog2(WIDTH);
    localparam int Y_W    = $clog2(HEIGHT);
    localparam int CNT_W  = $clog2(FRAME_PIXELS + 1);
    localparam int SUM_W  = 10;
    localparam int NUM_W  = 3;

    // divide by three: (s * 683) >> 11, exact for s below 768
    localparam int DIV3_MUL   = 683;
    localparam int DIV3_SHIFT = 11;
    localparam int PROD_W     = SUM_W + 10;

    // key detection on the top five bits of each byte
    localparam logic [4:0] KEY_SET = 5'h1F;
    localparam logic [4:0] KEY_CLR = 5'h00;

    localparam logic [7:0] ALPHA_OPAQUE = 8'hFF;
    localparam logic [7:0] ALPHA_CLEAR  = 8'h00;

    // neighbor visiting order
    localparam logic [1:0] NB_LEFT  = 2'd0;
    localparam logic [1:0] NB_RIGHT = 2'd1;
    localparam logic [1:0] NB_UP    = 2'd2;
    localparam logic [1:0] NB_DOWN  = 2'd3;

    // controller to datapath
    typedef struct packed {
        logic       take_item;
        logic       cap_ctr;
        logic       nb_rd;
        logic       nb_acc;
        logic [1:0] nb_idx;
        logic       do_div;
        logic       load_out;
    } ckab_cmd_t;

    // datapath to controller
    typedef struct packed {
        logic item_emits;
        logic ctr_key;
        logic out_free;
    } ckab_stat_t;

    // pixel layout: red [7:0], green [15:8], blue [23:16]
    function automatic logic is_key(input logic [PIX_W-1:0] px);
        return (px[15:11] == KEY_SET) && (px[7:3] == KEY_CLR) && (px[23:19] == KEY_CLR);
    endfunction

endpackage

### src/ckab_ram.sv
module ckab_ram #(
    parameter int DATA_W = 8,
    parameter int DEPTH  = 16,
    localparam int ADDR_W = $clog2(DEPTH)
) (
    input  logic              aclk,
    input  logic              wr_en,
    input  logic [ADDR_W-1:0] wr_addr,
    input  logic [DATA_W-1:0] wr_data,
    input  logic [ADDR_W-1:0] rd_addr,
    output logic [DATA_W-1:0] rd_data
);

    logic [DATA_W-1:0] mem [DEPTH];
    logic [DATA_W-1:0] rd_data_reg;

    // one write port, one registered read port
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

### src/ckab_ctrl.sv
module ckab_ctrl
    import ckab_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_tvalid,
    output logic       s_tready,
    input  ckab_stat_t stat,
    output ckab_cmd_t  cmd
);

    localparam logic [2:0] ST_IDLE   = 3'd0;
    localparam logic [2:0] ST_CHK    = 3'd1;
    localparam logic [2:0] ST_NB_RD  = 3'd2;
    localparam logic [2:0] ST_NB_ACC = 3'd3;
    localparam logic [2:0] ST_DIV    = 3'd4;
    localparam logic [2:0] ST_FIN    = 3'd5;

    logic [2:0] state_reg, state_next;
    logic [1:0] nb_idx_reg, nb_idx_next;

    // state and neighbor counter
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg  <= ST_IDLE;
            nb_idx_reg <= NB_LEFT;
        end else begin
            state_reg  <= state_next;
            nb_idx_reg <= nb_idx_next;
        end
    end

    // next state and commands
    always_comb begin
        state_next  = state_reg;
        nb_idx_next = nb_idx_reg;
        cmd         = '0;
        cmd.nb_idx  = nb_idx_reg;
        s_tready    = 1'b0;
        case (state_reg)
            ST_IDLE: begin
                s_tready      = 1'b1;
                cmd.take_item = s_tvalid;
                if (s_tvalid && stat.item_emits) begin
                    state_next = ST_CHK;
                end
            end
            ST_CHK: begin
                cmd.cap_ctr = 1'b1;
                nb_idx_next = NB_LEFT;
                state_next  = stat.ctr_key ? ST_NB_RD : ST_FIN;
            end
            ST_NB_RD: begin
                cmd.nb_rd  = 1'b1;
                state_next = ST_NB_ACC;
            end
            ST_NB_ACC: begin
                cmd.nb_acc = 1'b1;
                if (nb_idx_reg == NB_DOWN) begin
                    state_next = ST_DIV;
                end else begin
                    nb_idx_next = nb_idx_reg + 2'd1;
                    state_next  = ST_NB_RD;
                end
            end
            ST_DIV: begin
                cmd.do_div = 1'b1;
                state_next = ST_FIN;
            end
            ST_FIN: begin
                if (stat.out_free) begin
                    cmd.load_out = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

### src/ckab_dpath.sv
module ckab_dpath
    import ckab_pkg::*;
(
    input  logic             aclk,
    input  logic             aresetn,
    input  logic [PIX_W-1:0] s_tdata,
    input  logic             s_tuser,
    input  logic             m_tready,
    output logic             m_tvalid,
    output logic [OUT_W-1:0] m_tdata,
    output logic             m_tlast,
    input  ckab_cmd_t        cmd,
    output ckab_stat_t       stat
);

    localparam logic [WIN_AW-1:0] WIN_LAST  = WIN_AW'(WIN_DEPTH - 1);
    localparam logic [WIN_AW:0]   WIN_DEP_X = (WIN_AW + 1)'(WIN_DEPTH);
    localparam logic [WIN_AW:0]   WIDTH_X   = (WIN_AW + 1)'(WIDTH);

    // counters and pointers
    logic [CNT_W-1:0]  in_cnt_reg, in_cnt_next;
    logic [WIN_AW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [WIN_AW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [X_W-1:0]    x_reg, x_next;
    logic [Y_W-1:0]    y_reg, y_next;

    // pixel under work
    logic [PIX_W-1:0]  ctr_reg;
    logic              key_reg;
    logic [SUM_W-1:0]  sum_r_reg, sum_g_reg, sum_b_reg;
    logic [NUM_W-1:0]  n_reg;
    logic [7:0]        q_r_reg, q_g_reg, q_b_reg;

    // output register
    logic              m_tvalid_reg;
    logic [OUT_W-1:0]  m_tdata_reg;
    logic              m_tlast_reg;

    logic              in_full;
    logic              wr_en;
    logic              last_px;
    logic [WIN_AW-1:0] nb_addr;
    logic              nb_ok;
    logic [WIN_AW-1:0] ram_rd_addr;
    logic [PIX_W-1:0]  ram_rd_data;
    logic [WIN_AW:0]   up_sum, dn_sum;

    function automatic logic [7:0] div_by_n(input logic [SUM_W-1:0] s,
                                            input logic [NUM_W-1:0] n);
        logic [PROD_W-1:0] prod;
        logic [7:0]        q;
        prod = PROD_W'(s) * PROD_W'(DIV3_MUL);
        case (n)
            3'd1:    q = s[7:0];
            3'd2:    q = s[8:1];
            3'd3:    q = prod[DIV3_SHIFT +: 8];
            3'd4:    q = s[9:2];
            default: q = 8'h00;
        endcase
        return q;
    endfunction

    // input side status
    assign in_full = (in_cnt_reg == CNT_W'(FRAME_PIXELS));
    assign wr_en   = cmd.take_item && !s_tuser && !in_full;
    assign last_px = (x_reg == X_W'(WIDTH - 1)) && (y_reg == Y_W'(HEIGHT - 1));

    assign stat.item_emits = s_tuser ? in_full
                                     : (!in_full && (in_cnt_reg >= CNT_W'(WIDTH)));
    assign stat.ctr_key    = is_key(ram_rd_data);
    assign stat.out_free   = !m_tvalid_reg || m_tready;

    // neighbor addresses, modulo the window depth
    assign up_sum = {1'b0, rd_ptr_reg} + WIN_DEP_X - WIDTH_X;
    assign dn_sum = {1'b0, rd_ptr_reg} + WIDTH_X;

    always_comb begin
        nb_addr = rd_ptr_reg;
        nb_ok   = 1'b0;
        case (cmd.nb_idx)
            NB_LEFT: begin
                nb_addr = (rd_ptr_reg == '0) ? WIN_LAST : rd_ptr_reg - WIN_AW'(1);
                nb_ok   = (x_reg != '0);
            end
            NB_RIGHT: begin
                nb_addr = (rd_ptr_reg == WIN_LAST) ? '0 : rd_ptr_reg + WIN_AW'(1);
                nb_ok   = (x_reg != X_W'(WIDTH - 1));
            end
            NB_UP: begin
                nb_addr = (up_sum >= WIN_DEP_X) ? WIN_AW'(up_sum - WIN_DEP_X)
                                                : WIN_AW'(up_sum);
                nb_ok   = (y_reg != '0);
            end
            NB_DOWN: begin
                nb_addr = (dn_sum >= WIN_DEP_X) ? WIN_AW'(dn_sum - WIN_DEP_X)
                                                : WIN_AW'(dn_sum);
                nb_ok   = (y_reg != Y_W'(HEIGHT - 1));
            end
            default: begin
                nb_addr = rd_ptr_reg;
                nb_ok   = 1'b0;
            end
        endcase
    end

    assign ram_rd_addr = cmd.nb_rd ? nb_addr : rd_ptr_reg;

    // line window
    ckab_ram #(
        .DATA_W (PIX_W),
        .DEPTH  (WIN_DEPTH)
    ) u_win (
        .aclk    (aclk),
        .wr_en   (wr_en),
        .wr_addr (wr_ptr_reg),
        .wr_data (s_tdata),
        .rd_addr (ram_rd_addr),
        .rd_data (ram_rd_data)
    );

    // counter next values
    always_comb begin
        in_cnt_next = in_cnt_reg;
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        x_next      = x_reg;
        y_next      = y_reg;
        if (wr_en) begin
            in_cnt_next = in_cnt_reg + CNT_W'(1);
            wr_ptr_next = (wr_ptr_reg == WIN_LAST) ? '0 : wr_ptr_reg + WIN_AW'(1);
        end
        if (cmd.load_out) begin
            if (last_px) begin
                in_cnt_next = '0;
                wr_ptr_next = '0;
                rd_ptr_next = '0;
                x_next      = '0;
                y_next      = '0;
            end else begin
                rd_ptr_next = (rd_ptr_reg == WIN_LAST) ? '0 : rd_ptr_reg + WIN_AW'(1);
                if (x_reg == X_W'(WIDTH - 1)) begin
                    x_next = '0;
                    y_next = y_reg + Y_W'(1);
                end else begin
                    x_next = x_reg + X_W'(1);
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_cnt_reg <= '0;
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            x_reg      <= '0;
            y_reg      <= '0;
        end else begin
            in_cnt_reg <= in_cnt_next;
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            x_reg      <= x_next;
            y_reg      <= y_next;
        end
    end

    // center capture, neighbor sums and the divide
    always_ff @(posedge aclk) begin
        if (cmd.cap_ctr) begin
            ctr_reg   <= ram_rd_data;
            key_reg   <= is_key(ram_rd_data);
            sum_r_reg <= '0;
            sum_g_reg <= '0;
            sum_b_reg <= '0;
            n_reg     <= '0;
        end else if (cmd.nb_acc && nb_ok && !is_key(ram_rd_data)) begin
            sum_r_reg <= sum_r_reg + SUM_W'(ram_rd_data[7:0]);
            sum_g_reg <= sum_g_reg + SUM_W'(ram_rd_data[15:8]);
            sum_b_reg <= sum_b_reg + SUM_W'(ram_rd_data[23:16]);
            n_reg     <= n_reg + NUM_W'(1);
        end
        if (cmd.do_div) begin
            q_r_reg <= div_by_n(sum_r_reg, n_reg);
            q_g_reg <= div_by_n(sum_g_reg, n_reg);
            q_b_reg <= div_by_n(sum_b_reg, n_reg);
        end
    end

    // output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (cmd.load_out) begin
            m_tvalid_reg <= 1'b1;
        end else if (m_tready) begin
            m_tvalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load_out) begin
            m_tlast_reg <= last_px;
            if (key_reg) begin
                m_tdata_reg <= {q_b_reg, q_g_reg, q_r_reg, ALPHA_CLEAR};
            end else begin
                m_tdata_reg <= {ctr_reg, ALPHA_OPAQUE};
            end
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tlast  = m_tlast_reg;

    // checks
    a_ptr_range: assert property (@(posedge aclk) disable iff (!aresetn)
        (rd_ptr_reg <= WIN_LAST) && (wr_ptr_reg <= WIN_LAST))
        else $error("window pointer out of range");

    a_load_free: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.load_out |-> stat.out_free)
        else $error("output register overwritten");

    a_frame_end: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.load_out && last_px |=> (in_cnt_reg == '0) && (rd_ptr_reg == '0) && m_tlast)
        else $error("frame end did not clear counters");

    a_count_max: assert property (@(posedge aclk) disable iff (!aresetn)
        in_cnt_reg <= CNT_W'(FRAME_PIXELS))
        else $error("input count past frame size");

endmodule

### src/color_key_alpha_bleed.sv
// Color-key transparency with edge bleed, RGB888 in, ARGB8888 out.
// Slave channel: s_tdata carries one pixel (red, green, blue); s_tuser set
// marks a drain request, which carries no pixel. Pixels come in raster order,
// a WIDTH by HEIGHT frame. Master channel: one ARGB pixel per result, m_tlast
// set on the last pixel of the frame.
// Output runs WIDTH pixels behind the input: the pixel of each request is
// emitted once its lower neighbor has arrived; after the whole frame, each
// drain request emits one pixel of the final row. Other requests give no
// result. A request that emits an opaque pixel reads only the center; one
// that emits a key pixel also reads the four neighbors, one per visit, over
// the single read port of the line window, then does a registered divide.
// A new request is taken only once the controller is back in idle. The
// result sits in an output register; the next request is taken while it
// waits, and the controller holds its own result until that register frees.
// Reset (aresetn low, synchronous) clears the frame counters, controller state
// and output valid; the line window needs no clearing.
module color_key_alpha_bleed
    import ckab_pkg::*;
(
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             s_tvalid,
    output logic             s_tready,
    input  logic [PIX_W-1:0] s_tdata,   // red [7:0], green [15:8], blue [23:16]
    input  logic             s_tuser,   // drain
    output logic             m_tvalid,
    input  logic             m_tready,
    output logic [OUT_W-1:0] m_tdata,   // alpha [7:0], out_red [15:8],
                                        // out_green [23:16], out_blue [31:24]
    output logic             m_tlast    // last_of_frame
);

    ckab_cmd_t  cmd;
    ckab_stat_t stat;

    ckab_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .stat     (stat),
        .cmd      (cmd)
    );

    ckab_dpath u_dpath (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tready (m_tready),
        .m_tvalid (m_tvalid),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast),
        .cmd      (cmd),
        .stat     (stat)
    );

endmodule
